// File: rtl/blpf_pkg.sv
// Shared types and constants for the binary load packet framer.
`timescale 1ns / 1ps
`default_nettype none

package blpf_pkg;

    localparam logic [7:0] SOH   = 8'd1;
    localparam int         CSLEN = 1024;
    localparam int         LEN_W = 6;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STORE,
        ST_PKT
    } t_state;

    typedef enum logic [1:0] {
        AF_STORE,
        AF_EMPTY,
        AF_DONE
    } t_after;

    typedef enum logic [2:0] {
        P_SOH,
        P_LEN,
        P_ADR,
        P_DATA,
        P_CK,
        P_END,
        P_ERR
    } t_phase;

    typedef struct packed {
        logic             start;
        logic             err;
        logic             last;
        logic [31:0]      addr;
        logic [LEN_W-1:0] len;
    } t_pkt_req;

endpackage

`default_nettype wire

// File: rtl/blpf_if.sv
// Request and result channel interfaces of the binary load packet framer.
`timescale 1ns / 1ps
`default_nettype none

interface blpf_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;

    modport source (output valid, req_type, byte_address, data_byte, input ready);
    modport sink   (input valid, req_type, byte_address, data_byte, output ready);
endinterface

interface blpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       no_data_error;

    modport source (output valid, out_byte, last, no_data_error, input ready);
    modport sink   (input valid, out_byte, last, no_data_error, output ready);
endinterface

`default_nettype wire

// File: rtl/blpf_store.sv
// Packet byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module blpf_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/blpf_emit.sv
// Packet byte sequencer with checksum insertion and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module blpf_emit #(
    parameter int CHECK_INTERVAL = 16,
    parameter int AW             = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire blpf_pkg::t_pkt_req  i_req,
    input  wire logic [7:0]          i_rdata,
    output logic      [AW-1:0]       o_raddr,
    output logic                     o_done,
    blpf_out_if.source               o_out
);

    localparam int CW = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;
    localparam int LW = blpf_pkg::LEN_W;

    logic                   r_busy, n_busy;
    blpf_pkg::t_phase       r_phase, n_phase;
    logic [1:0]             r_k, n_k;
    logic [AW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [7:0]             r_sum, n_sum;
    logic [LW-1:0]          r_len, n_len;
    logic [31:0]            r_addr, n_addr;
    logic                   r_last, n_last;

    logic                   r_ov;
    logic [7:0]             r_ob;
    logic                   r_ol;
    logic                   r_oe;

    logic                   w_free;
    logic [7:0]             w_byte;
    logic                   w_last;
    logic                   w_err;

    function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    assign w_free  = !r_ov || o_out.ready;
    assign o_done  = r_busy && w_free &&
                     (r_phase == blpf_pkg::P_END || r_phase == blpf_pkg::P_ERR);
    assign o_raddr = n_j;

    // Byte presented in the current phase.
    always_comb begin
        w_byte = 8'd0;
        w_last = 1'b0;
        w_err  = 1'b0;
        case (r_phase)
            blpf_pkg::P_SOH:  w_byte = blpf_pkg::SOH;
            blpf_pkg::P_LEN:  w_byte = word_byte(32'(r_len), r_k);
            blpf_pkg::P_ADR:  w_byte = word_byte(r_addr, r_k);
            blpf_pkg::P_DATA: w_byte = i_rdata;
            blpf_pkg::P_CK:   w_byte = 8'd0 - r_sum;
            blpf_pkg::P_END: begin
                w_byte = 8'd0 - r_sum;
                w_last = r_last;
            end
            blpf_pkg::P_ERR: begin
                w_byte = 8'd0;
                w_last = 1'b1;
                w_err  = 1'b1;
            end
            default: w_byte = 8'd0;
        endcase
    end

    // Phase sequencing and counters.
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_k     = r_k;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_len   = r_len;
        n_addr  = r_addr;
        n_last  = r_last;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy  = 1'b1;
                n_phase = i_req.err ? blpf_pkg::P_ERR : blpf_pkg::P_SOH;
                n_len   = i_req.len;
                n_addr  = i_req.addr;
                n_last  = i_req.last;
                n_k     = 2'd0;
                n_j     = '0;
                n_cnt   = '0;
                n_sum   = 8'd0;
            end
        end else if (w_free) begin
            case (r_phase)
                blpf_pkg::P_SOH: begin
                    n_phase = blpf_pkg::P_LEN;
                    n_k     = 2'd0;
                end
                blpf_pkg::P_LEN: begin
                    n_sum = r_sum + w_byte;
                    n_k   = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_phase = blpf_pkg::P_ADR;
                    end
                end
                blpf_pkg::P_ADR: begin
                    n_sum = r_sum + w_byte;
                    n_k   = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_phase = (r_len == '0) ? blpf_pkg::P_END : blpf_pkg::P_DATA;
                    end
                end
                blpf_pkg::P_DATA: begin
                    n_sum = r_sum + w_byte;
                    if (LW'(r_j) + LW'(1) == r_len) begin
                        n_phase = blpf_pkg::P_END;
                    end else begin
                        n_j = r_j + AW'(1);
                        if (r_cnt == CW'(CHECK_INTERVAL - 1)) begin
                            n_cnt   = '0;
                            n_phase = blpf_pkg::P_CK;
                        end else begin
                            n_cnt = r_cnt + CW'(1);
                        end
                    end
                end
                blpf_pkg::P_CK: begin
                    n_phase = blpf_pkg::P_DATA;
                end
                blpf_pkg::P_END: begin
                    n_busy  = 1'b0;
                    n_phase = blpf_pkg::P_SOH;
                end
                blpf_pkg::P_ERR: begin
                    n_busy  = 1'b0;
                    n_phase = blpf_pkg::P_SOH;
                end
                default: begin
                    n_busy  = 1'b0;
                    n_phase = blpf_pkg::P_SOH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= blpf_pkg::P_SOH;
            r_ov    <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            if (w_free) begin
                r_ov <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_j    <= n_j;
        r_cnt  <= n_cnt;
        r_sum  <= n_sum;
        r_len  <= n_len;
        r_addr <= n_addr;
        r_last <= n_last;
        if (w_free) begin
            r_ob <= w_byte;
            r_ol <= w_last;
            r_oe <= w_err;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.out_byte      = r_ob;
    assign o_out.last          = r_ol;
    assign o_out.no_data_error = r_oe;

endmodule

`default_nettype wire

// File: rtl/binary_load_packet_framer.sv
// Top level of the binary load packet framer: request control and run tracking.
`timescale 1ns / 1ps
`default_nettype none

// The request channel i_in carries a data byte with its 32-bit load address,
// or an end-of-stream marker. The result channel o_out carries the framed
// byte stream, one byte per result, with last set on the final byte caused
// by a request and no_data_error set on the single result that answers an
// end of stream when no data was ever seen.
// A data request that extends the current run is taken in, evaluated and
// written to the packet store and gives no result unless it fills the store.
// A request that closes a packet occupies the block while the packet drains:
// the packet sequencer sends one byte per cycle while the receiver is ready,
// the 9 header bytes, the data bytes with their inserted checksums and the
// closing checksum. N data bytes make 10 + N + (N - 1) / CHECK_INTERVAL
// bytes (10 when empty). The store's single read port is read one entry per
// cycle unless the sequencer waits, one entry ahead of the byte being sent.
// A new request is taken only once the previous one has been fully handled,
// but the last result may still wait in the output register then.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits. Reset clears the run state; the store needs no clearing,
// because entries are read only after they are written in the current run.
module binary_load_packet_framer #(
    parameter int BUFFER_BYTES   = 32,
    parameter int CHECK_INTERVAL = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    blpf_in_if.sink     i_in,
    blpf_out_if.source  o_out
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int LW = blpf_pkg::LEN_W;

    blpf_pkg::t_state   r_state, n_state;
    blpf_pkg::t_after   r_after, n_after;
    blpf_pkg::t_pkt_req r_req, n_req;

    logic               r_type;
    logic [31:0]        r_addr;
    logic [7:0]         r_data;

    logic [LW-1:0]      r_fill, n_fill;
    logic [31:0]        r_next, n_next;
    logic               r_seen, n_seen;

    logic               w_accept;
    logic               w_jump;
    logic [31:0]        w_base;
    logic               w_full;
    logic               w_done;
    logic               w_we;
    logic [7:0]         w_rdata;
    logic [AW-1:0]      w_raddr;

    assign i_in.ready = (r_state == blpf_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_jump     = (r_addr != r_next);
    assign w_base     = w_jump ? r_addr : r_next;
    assign w_full     = (r_fill + LW'(1) == LW'(BUFFER_BYTES));
    assign w_we       = (r_state == blpf_pkg::ST_STORE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            blpf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = blpf_pkg::ST_EVAL;
                end
            end
            blpf_pkg::ST_EVAL: begin
                if (r_type == blpf_pkg::REQ_DATA && !(w_jump && r_fill != '0)) begin
                    n_state = blpf_pkg::ST_STORE;
                end else begin
                    n_state = blpf_pkg::ST_PKT;
                end
            end
            blpf_pkg::ST_STORE: begin
                n_state = w_full ? blpf_pkg::ST_PKT : blpf_pkg::ST_IDLE;
            end
            blpf_pkg::ST_PKT: begin
                if (w_done) begin
                    case (r_after)
                        blpf_pkg::AF_STORE: n_state = blpf_pkg::ST_STORE;
                        blpf_pkg::AF_EMPTY: n_state = blpf_pkg::ST_PKT;
                        default:            n_state = blpf_pkg::ST_IDLE;
                    endcase
                end
            end
            default: n_state = blpf_pkg::ST_IDLE;
        endcase
    end

    // Run state updates and packet requests to the sequencer.
    always_comb begin
        n_after     = r_after;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_fill      = r_fill;
        n_next      = r_next;
        n_seen      = r_seen;
        case (r_state)
            blpf_pkg::ST_EVAL: begin
                if (r_type == blpf_pkg::REQ_DATA) begin
                    if (w_jump && r_fill != '0) begin
                        // The run breaks: the pending packet closes this request's
                        // results, since one stored byte cannot fill the store.
                        n_req   = '{start: 1'b1, err: 1'b0, last: 1'b1,
                                    addr: r_next - 32'(r_fill), len: r_fill};
                        n_after = blpf_pkg::AF_STORE;
                        n_fill  = '0;
                    end
                end else begin
                    if (!r_seen) begin
                        n_req   = '{start: 1'b1, err: 1'b1, last: 1'b1,
                                    addr: 32'd0, len: '0};
                        n_after = blpf_pkg::AF_DONE;
                    end else if (r_fill != '0) begin
                        n_req   = '{start: 1'b1, err: 1'b0, last: 1'b0,
                                    addr: r_next - 32'(r_fill), len: r_fill};
                        n_after = blpf_pkg::AF_EMPTY;
                    end else begin
                        n_req   = '{start: 1'b1, err: 1'b0, last: 1'b1,
                                    addr: 32'd0, len: '0};
                        n_after = blpf_pkg::AF_DONE;
                    end
                    n_fill = '0;
                    n_next = 32'd0;
                    n_seen = 1'b0;
                end
            end
            blpf_pkg::ST_STORE: begin
                n_seen = 1'b1;
                n_next = w_base + 32'd1;
                if (w_full) begin
                    n_req   = '{start: 1'b1, err: 1'b0, last: 1'b1,
                                addr: w_base - 32'(r_fill), len: LW'(BUFFER_BYTES)};
                    n_after = blpf_pkg::AF_DONE;
                    n_fill  = '0;
                end else begin
                    n_fill = r_fill + LW'(1);
                end
            end
            blpf_pkg::ST_PKT: begin
                if (w_done && r_after == blpf_pkg::AF_EMPTY) begin
                    // End of stream after data always finishes with an empty packet.
                    n_req   = '{start: 1'b1, err: 1'b0, last: 1'b1,
                                addr: 32'd0, len: '0};
                    n_after = blpf_pkg::AF_DONE;
                end
            end
            default: begin
                n_after = r_after;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blpf_pkg::ST_IDLE;
            r_req   <= '0;
            r_fill  <= '0;
            r_next  <= 32'd0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_fill  <= n_fill;
            r_next  <= n_next;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after <= n_after;
        if (w_accept) begin
            r_type <= i_in.req_type;
            r_addr <= i_in.byte_address;
            r_data <= i_in.data_byte;
        end
    end

    blpf_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    blpf_emit #(
        .CHECK_INTERVAL (CHECK_INTERVAL),
        .AW             (AW)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_rdata (w_rdata),
        .o_raddr (w_raddr),
        .o_done  (w_done),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_binary_load_packet_framer.sv
// Self-checking testbench for the binary load packet framer.
`timescale 1ns / 1ps

module tb_binary_load_packet_framer;

    localparam int BUFFER_BYTES   = 32;
    localparam int CHECK_INTERVAL = 16;
    localparam int RANDOM_ITEMS   = 150;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       no_data_error;
    } t_framed_byte;

    // Tracks the framer's run state and keeps the queue of framed bytes that
    // the accepted requests are due to produce.
    class t_framer_scoreboard;
        logic [7:0]   held_bytes [BUFFER_BYTES];
        int unsigned  held_count;
        logic [31:0]  run_next_addr;
        bit           any_data;
        t_framed_byte pending_bytes [$];
        int           failures;

        function new();
            clear_run();
            failures = 0;
        endfunction

        function void clear_run();
            held_count    = 0;
            run_next_addr = '0;
            any_data      = 1'b0;
        endfunction

        function void queue_byte(logic [7:0] b);
            pending_bytes.push_back('{out_byte: b, last: 1'b0, no_data_error: 1'b0});
        endfunction

        // Sends a 32-bit field most significant byte first and folds it into the sum.
        function logic [7:0] queue_word(logic [31:0] w, logic [7:0] sum);
            for (int s = 24; s >= 0; s -= 8) begin
                queue_byte(w[s +: 8]);
                sum = sum + w[s +: 8];
            end
            return sum;
        endfunction

        function void queue_packet(logic [31:0] start, int unsigned len);
            logic [7:0] sum;
            logic [7:0] d;
            sum = 8'h00;
            queue_byte(blpf_pkg::SOH);
            sum = queue_word(len, sum);
            sum = queue_word(start, sum);
            for (int unsigned j = 0; j < len; j++) begin
                // A checksum is slipped in after every CHECK_INTERVAL-th data byte but the last.
                if (j > 0 && (j % CHECK_INTERVAL) == 0)
                    queue_byte(8'h00 - sum);
                d = (j < BUFFER_BYTES) ? held_bytes[j] : 8'h00;
                queue_byte(d);
                sum = sum + d;
            end
            queue_byte(8'h00 - sum);
        endfunction

        function void close_run();
            if (held_count > 0) begin
                queue_packet(run_next_addr - held_count, held_count);
                held_count = 0;
            end
        endfunction

        function void note_request(logic kind, logic [31:0] addr, logic [7:0] data);
            int queued_at_entry;
            queued_at_entry = pending_bytes.size();
            if (kind == blpf_pkg::REQ_DATA) begin
                if (addr != run_next_addr) begin
                    close_run();
                    run_next_addr = addr;
                end
                if (held_count < BUFFER_BYTES)
                    held_bytes[held_count] = data;
                held_count++;
                run_next_addr = run_next_addr + 1;
                if (held_count >= BUFFER_BYTES)
                    close_run();
                any_data = 1'b1;
            end else begin
                if (!any_data) begin
                    // End of stream with nothing seen answers with a lone error byte.
                    pending_bytes.push_back('{out_byte: 8'h00, last: 1'b1,
                                              no_data_error: 1'b1});
                    clear_run();
                    return;
                end
                close_run();
                queue_packet(32'h0, 0);
                clear_run();
            end
            if (pending_bytes.size() > queued_at_entry)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [7:0] b, logic l, logic e);
            t_framed_byte want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: out_byte %0h last %0b no_data_error %0b", b, l, e);
                failures++;
                return;
            end
            want = pending_bytes.pop_front();
            if (b !== want.out_byte) begin
                $error("out_byte mismatch: expected %0h, actual %0h", want.out_byte, b);
                failures++;
            end
            if (l !== want.last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, l);
                failures++;
            end
            if (e !== want.no_data_error) begin
                $error("no_data_error mismatch: expected %0b, actual %0b",
                       want.no_data_error, e);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    blpf_in_if  req_bus ();
    blpf_out_if res_bus ();

    t_framer_scoreboard sb;
    int                 items_sent;
    int                 burst_left;
    logic [31:0]        last_run_end;

    binary_load_packet_framer #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .CHECK_INTERVAL (CHECK_INTERVAL)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (res_bus)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Both channels are observed at the rising edge, where every input set at
    // the falling edge has long settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready)
                sb.note_request(req_bus.req_type, req_bus.byte_address, req_bus.data_byte);
            if (res_bus.valid && res_bus.ready)
                sb.check_result(res_bus.out_byte, res_bus.last, res_bus.no_data_error);
        end
    end

    // The receiver rotates through four behaviors: always ready, random
    // stalls, a fixed one-in-five stall, and rare long stalls.
    initial begin
        int cyc;
        int stall_left;
        cyc             = 0;
        stall_left      = 0;
        res_bus.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            case ((cyc / 256) % 4)
                0: res_bus.ready = 1'b1;
                1: res_bus.ready = ($urandom_range(0, 9) >= 3);
                2: res_bus.ready = ((cyc % 5) != 0);
                default: begin
                    if (stall_left > 0) begin
                        res_bus.ready = 1'b0;
                        stall_left--;
                    end else begin
                        res_bus.ready = 1'b1;
                        if ($urandom_range(0, 19) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // Presents one request and holds it until accepted. The sender works in
    // bursts; at the end of a burst it may drop valid for a few cycles.
    task automatic send_request(input logic kind, input logic [31:0] addr,
                                input logic [7:0] data);
        int gap;
        @(negedge i_clk);
        req_bus.valid        = 1'b1;
        req_bus.req_type     = kind;
        req_bus.byte_address = addr;
        req_bus.data_byte    = data;
        do @(posedge i_clk); while (!req_bus.ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                req_bus.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_run(input logic [31:0] start, input int len);
        for (int i = 0; i < len; i++)
            send_request(blpf_pkg::REQ_DATA, start + i, 8'($urandom_range(0, 255)));
        last_run_end = start + len;
    endtask

    // Start addresses lean toward the interesting spots: zero, just below the
    // wrap point, and just beside the previous run.
    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            2: return last_run_end + $urandom_range(1, 3);
            3: return last_run_end - $urandom_range(1, 3);
            default: return $urandom();
        endcase
    endfunction

    // Mostly short runs, with some around the checksum interval and the
    // store size, and a few that fill the store at least once.
    function automatic int pick_run_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(1, 8);
            5, 6:          return $urandom_range(9, 20);
            7:             return $urandom_range(CHECK_INTERVAL - 1, CHECK_INTERVAL + 1);
            8:             return $urandom_range(BUFFER_BYTES - 1, BUFFER_BYTES + 1);
            default:       return $urandom_range(BUFFER_BYTES + 2, 2 * BUFFER_BYTES + 6);
        endcase
    endfunction

    initial begin
        int directed_count;
        int pick;
        sb                   = new();
        items_sent           = 0;
        burst_left           = 0;
        last_run_end         = '0;
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = blpf_pkg::REQ_DATA;
        req_bus.byte_address = '0;
        req_bus.data_byte    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // End of stream with no data, twice in a row.
        send_request(blpf_pkg::REQ_END, 32'h0, 8'h00);
        send_request(blpf_pkg::REQ_END, 32'hFFFF_FFFF, 8'hFF);
        // A run starting at zero needs no jump out of the reset state.
        send_request(blpf_pkg::REQ_DATA, 32'h0000_0000, 8'h00);
        send_request(blpf_pkg::REQ_DATA, 32'h0000_0001, 8'hFF);
        // Jump back to the top of the address space, then wrap through zero.
        send_request(blpf_pkg::REQ_DATA, 32'hFFFF_FFFF, 8'hA5);
        send_request(blpf_pkg::REQ_DATA, 32'h0000_0000, 8'h5A);
        // Repeating an address is a jump as well.
        send_request(blpf_pkg::REQ_DATA, 32'h0000_0000, 8'h3C);
        send_request(blpf_pkg::REQ_DATA, 32'h8000_0000, 8'h80);
        send_request(blpf_pkg::REQ_DATA, 32'h7FFF_FFFF, 8'h01);
        send_request(blpf_pkg::REQ_END, 32'h1234_5678, 8'h9C);
        // The run state must be back at reset: zero is consecutive again.
        send_request(blpf_pkg::REQ_DATA, 32'h0000_0000, 8'h7F);
        send_request(blpf_pkg::REQ_END, 32'h0, 8'h00);
        send_request(blpf_pkg::REQ_DATA, 32'hAAAA_AAAA, 8'h55);
        send_request(blpf_pkg::REQ_DATA, 32'h5555_5555, 8'hAA);
        send_request(blpf_pkg::REQ_DATA, 32'h5555_5556, 8'hC3);
        send_request(blpf_pkg::REQ_END, 32'h0, 8'h00);
        directed_count = items_sent;

        // A run long enough to fill the store and cross the checksum interval.
        send_run($urandom(), BUFFER_BYTES + 1);
        send_request(blpf_pkg::REQ_END, 32'h0, 8'h00);

        while (items_sent < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_run(pick_start(), pick_run_length());
                send_request(blpf_pkg::REQ_END, $urandom(), 8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                send_request(blpf_pkg::REQ_END, $urandom(), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_request(blpf_pkg::REQ_DATA, $urandom(),
                                 8'($urandom_range(0, 255)));
            end
        end
        send_request(blpf_pkg::REQ_END, 32'h0, 8'h00);
        @(negedge i_clk);
        req_bus.valid = 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
